>>> hdl/bbb_pkg.sv
// Shared types, codes and helpers for the 3x3 box blur blend block.
package bbb_pkg;

	// Fixed field and register widths
	localparam int CHAN_W     = 8;
	localparam int COORD_W    = 10;
	localparam int DIM_W      = 11;
	localparam int STRENGTH_W = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int SUM_W      = 12;
	localparam int CNT_W      = 4;
	localparam int TAP_W      = 4;
	localparam int EMIT_N     = 4;
	localparam int SEL_W      = 2;

	// Parameter defaults
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Register reset values
	localparam logic [DIM_W-1:0]      WIDTH_RST    = 11'd256;
	localparam logic [DIM_W-1:0]      HEIGHT_RST   = 11'd256;
	localparam logic [STRENGTH_W-1:0] STRENGTH_RST = 9'd0;
	localparam logic [STRENGTH_W-1:0] STRENGTH_ONE = 9'd256;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd2;

	// Last neighbor tap of the 3x3 window, and its center
	localparam logic [TAP_W-1:0] TAP_LAST   = 4'd8;
	localparam logic [TAP_W-1:0] TAP_CENTER = 4'd4;

	// Which result of a pixel is being produced
	localparam logic [SEL_W-1:0] SEL_UP_LEFT = 2'd0;
	localparam logic [SEL_W-1:0] SEL_UP      = 2'd1;
	localparam logic [SEL_W-1:0] SEL_LEFT    = 2'd2;
	localparam logic [SEL_W-1:0] SEL_HERE    = 2'd3;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_column;
		logic [COORD_W-1:0] out_row;
		logic [CHAN_W-1:0]  red_out;
		logic [CHAN_W-1:0]  green_out;
		logic [CHAN_W-1:0]  blue_out;
		logic               run_last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_READ,
		ST_DRAIN,
		ST_DIV,
		ST_BLEND,
		ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic             accept;
		logic             clear;
		logic             issue;
		logic [TAP_W-1:0] tap;
		logic             div_en;
		logic             blend_en;
		logic [SEL_W-1:0] sel;
		logic             last;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [EMIT_N-1:0] emit_mask;
	} dp_stat_t;

	// Truncating divide of a window sum by its neighbor count (1,2,3,4,6,9)
	function automatic logic [CHAN_W-1:0] avg_div(input logic [SUM_W-1:0] sum,
		input logic [CNT_W-1:0] cnt);
		logic [SUM_W+15:0] prod;
		logic [CHAN_W-1:0] q;
		prod = '0;
		q    = '0;
		case (cnt)
			4'd2: q = CHAN_W'(sum >> 1);
			4'd3: begin
				prod = (SUM_W+16)'(sum) * (SUM_W+16)'(21846);
				q    = CHAN_W'(prod >> 16);
			end
			4'd4: q = CHAN_W'(sum >> 2);
			4'd6: begin
				prod = (SUM_W+16)'(sum) * (SUM_W+16)'(10923);
				q    = CHAN_W'(prod >> 16);
			end
			4'd9: begin
				prod = (SUM_W+16)'(sum) * (SUM_W+16)'(7282);
				q    = CHAN_W'(prod >> 16);
			end
			default: q = CHAN_W'(sum);
		endcase
		return q;
	endfunction

endpackage

>>> hdl/bbb_ctrl.sv
// Controller: sequences the results of each accepted pixel.
module bbb_ctrl
	import bbb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t            state_q, state_nx;
	logic [EMIT_N-1:0] mask_q;
	logic [TAP_W-1:0]  tap_q;
	logic [SEL_W-1:0]  sel;
	logic [EMIT_N-1:0] rest;
	logic              accept;
	logic              out_done;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_done = (state_q == ST_OUT) && !out_stall;

	// lowest pending result goes first
	always_comb begin
		sel = SEL_HERE;
		if (mask_q[0]) begin
			sel = SEL_UP_LEFT;
		end else if (mask_q[1]) begin
			sel = SEL_UP;
		end else if (mask_q[2]) begin
			sel = SEL_LEFT;
		end
		rest = mask_q & ~(EMIT_N'(1) << sel);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nx = ST_PICK;
			ST_PICK:  state_nx = (mask_q == '0) ? ST_IDLE : ST_READ;
			ST_READ:  if (tap_q == TAP_LAST) state_nx = ST_DRAIN;
			ST_DRAIN: state_nx = ST_DIV;
			ST_DIV:   state_nx = ST_BLEND;
			ST_BLEND: state_nx = ST_OUT;
			ST_OUT:   if (!out_stall) state_nx = ST_PICK;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		out_valid    = (state_q == ST_OUT);
		cmd          = '0;
		cmd.accept   = accept;
		cmd.clear    = (state_q == ST_PICK);
		cmd.issue    = (state_q == ST_READ);
		cmd.tap      = tap_q;
		cmd.div_en   = (state_q == ST_DIV);
		cmd.blend_en = (state_q == ST_BLEND);
		cmd.sel      = sel;
		cmd.last     = (rest == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mask_q  <= '0;
			tap_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				mask_q <= stat.emit_mask;
			end else if (out_done) begin
				mask_q <= rest;
			end
			if (state_q == ST_READ) begin
				tap_q <= tap_q + TAP_W'(1);
			end else begin
				tap_q <= '0;
			end
		end
	end

	// a pixel beat always leads to result planning
	a_accept_pick: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_PICK)
		else $error("accepted pixel not followed by planning");

	// a stalled result holds its slot
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_stall) |=> state_q == ST_OUT && $stable(mask_q))
		else $error("stalled result dropped");

	// window reads only happen for a pending result
	a_read_mask: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> mask_q != '0 && tap_q <= TAP_LAST)
		else $error("window read without pending result");

endmodule

>>> hdl/bbb_datapath.sv
// Datapath: line stores, frame counters, window sums, divide and blend.
module bbb_datapath
	import bbb_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pixel_t                in_data,
	output result_t               out_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]      cfg_data,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat
);

	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DEPTH = 3 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	// configuration
	logic [DIM_W-1:0]      width_q, height_q;
	logic [STRENGTH_W-1:0] strength_q;
	logic [DIM_W-1:0]      eff_w, eff_h;
	logic [STRENGTH_W-1:0] sat_s;

	// frame position
	logic [XW-1:0] col_q, x_eff, cx_q, ecol, nx;
	logic [YW-1:0] row_q, y_eff, cy_q, erow;
	logic [1:0]    bank_q, b_eff, cbank_q, ebank, nbank;
	logic          x_end, y_end;

	// window
	logic [23:0]       mem [0:DEPTH-1];
	logic [23:0]       rd_q;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic              inframe;
	logic              take_s1, center_s1;
	logic [SUM_W-1:0]  sum_r_q, sum_g_q, sum_b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [23:0]       orig_q;
	logic [CHAN_W-1:0] avg_r_q, avg_g_q, avg_b_q;
	result_t           out_q;
	logic [1:0]        dxi, dyi;

	function automatic logic [1:0] bank_dec(input logic [1:0] b);
		return (b == 2'd0) ? 2'd2 : b - 2'd1;
	endfunction

	function automatic logic [1:0] bank_inc(input logic [1:0] b);
		return (b == 2'd2) ? 2'd0 : b + 2'd1;
	endfunction

	function automatic logic [AW-1:0] bank_base(input logic [1:0] b);
		logic [AW-1:0] base;
		base = '0;
		if (b == 2'd1) begin
			base = AW'(MAX_WIDTH);
		end else if (b == 2'd2) begin
			base = AW'(2 * MAX_WIDTH);
		end
		return base;
	endfunction

	function automatic logic [CHAN_W-1:0] blend(input logic [STRENGTH_W-1:0] s,
		input logic [CHAN_W-1:0] ov, input logic [CHAN_W-1:0] av);
		logic [18:0] acc;
		acc = 19'(STRENGTH_ONE - s) * 19'(ov) + 19'(s) * 19'(av) + 19'd128;
		return CHAN_W'(acc >> 8);
	endfunction

	// effective frame size and strength
	always_comb begin
		eff_w = width_q;
		if (width_q == '0) begin
			eff_w = DIM_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = DIM_W'(MAX_WIDTH);
		end
		eff_h = height_q;
		if (height_q == '0) begin
			eff_h = DIM_W'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eff_h = DIM_W'(MAX_HEIGHT);
		end
		sat_s = (strength_q > STRENGTH_ONE) ? STRENGTH_ONE : strength_q;
	end

	// current pixel position and the results it causes
	always_comb begin
		x_eff = (32'(col_q) >= 32'(eff_w)) ? '0 : col_q;
		y_eff = (32'(row_q) >= 32'(eff_h)) ? '0 : row_q;
		b_eff = (32'(row_q) >= 32'(eff_h)) ? 2'd0 : bank_q;
		x_end = (32'(x_eff) == 32'(eff_w) - 1);
		y_end = (32'(y_eff) == 32'(eff_h) - 1);
		stat.emit_mask[0] = (y_eff != '0) && (x_eff != '0);
		stat.emit_mask[1] = (y_eff != '0) && x_end;
		stat.emit_mask[2] = y_end && (x_eff != '0);
		stat.emit_mask[3] = y_end && x_end;
		wr_addr = bank_base(b_eff) + AW'(x_eff);
	end

	// config registers and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			strength_q <= STRENGTH_RST;
			col_q      <= '0;
			row_q      <= '0;
			bank_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					width_q <= cfg_data;
					col_q   <= '0;
					row_q   <= '0;
					bank_q  <= '0;
				end
				REG_HEIGHT: begin
					height_q <= cfg_data;
					col_q    <= '0;
					row_q    <= '0;
					bank_q   <= '0;
				end
				REG_STRENGTH: strength_q <= cfg_data[STRENGTH_W-1:0];
				default: ;
			endcase
		end else if (cmd.accept) begin
			if (x_end) begin
				col_q <= '0;
				if (y_end) begin
					row_q  <= '0;
					bank_q <= '0;
				end else begin
					row_q  <= y_eff + YW'(1);
					bank_q <= bank_inc(b_eff);
				end
			end else begin
				col_q <= x_eff + XW'(1);
				row_q <= y_eff;
				bank_q <= b_eff;
			end
		end
	end

	// capture the position of the accepted pixel
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cx_q    <= x_eff;
			cy_q    <= y_eff;
			cbank_q <= b_eff;
		end
	end

	// window center of the selected result and the current tap
	always_comb begin
		ecol  = ((cmd.sel == SEL_UP_LEFT) || (cmd.sel == SEL_LEFT)) ? cx_q - XW'(1) : cx_q;
		erow  = ((cmd.sel == SEL_UP_LEFT) || (cmd.sel == SEL_UP)) ? cy_q - YW'(1) : cy_q;
		ebank = ((cmd.sel == SEL_UP_LEFT) || (cmd.sel == SEL_UP)) ? bank_dec(cbank_q)
			: cbank_q;
		dyi = 2'd1;
		dxi = 2'd1;
		case (cmd.tap)
			4'd0: begin dyi = 2'd0; dxi = 2'd0; end
			4'd1: begin dyi = 2'd0; dxi = 2'd1; end
			4'd2: begin dyi = 2'd0; dxi = 2'd2; end
			4'd3: begin dyi = 2'd1; dxi = 2'd0; end
			4'd5: begin dyi = 2'd1; dxi = 2'd2; end
			4'd6: begin dyi = 2'd2; dxi = 2'd0; end
			4'd7: begin dyi = 2'd2; dxi = 2'd1; end
			4'd8: begin dyi = 2'd2; dxi = 2'd2; end
			default: begin dyi = 2'd1; dxi = 2'd1; end
		endcase
		inframe = 1'b1;
		nx      = ecol;
		nbank   = ebank;
		if (dxi == 2'd0) begin
			nx = ecol - XW'(1);
			if (ecol == '0) inframe = 1'b0;
		end else if (dxi == 2'd2) begin
			nx = ecol + XW'(1);
			if (32'(ecol) == 32'(eff_w) - 1) inframe = 1'b0;
		end
		if (dyi == 2'd0) begin
			nbank = bank_dec(ebank);
			if (erow == '0) inframe = 1'b0;
		end else if (dyi == 2'd2) begin
			nbank = bank_inc(ebank);
			if (32'(erow) == 32'(eff_h) - 1) inframe = 1'b0;
		end
		rd_addr = bank_base(nbank) + AW'(nx);
	end

	// line stores: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mem[wr_addr] <= in_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	// read tag pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1   <= 1'b0;
			center_s1 <= 1'b0;
		end else begin
			take_s1   <= cmd.issue && inframe;
			center_s1 <= cmd.issue && (cmd.tap == TAP_CENTER);
		end
	end

	// window sums, then divide, then blend into the output register
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			cnt_q   <= '0;
		end else if (take_s1) begin
			sum_r_q <= sum_r_q + SUM_W'(rd_q[23:16]);
			sum_g_q <= sum_g_q + SUM_W'(rd_q[15:8]);
			sum_b_q <= sum_b_q + SUM_W'(rd_q[7:0]);
			cnt_q   <= cnt_q + CNT_W'(1);
		end
		if (center_s1) begin
			orig_q <= rd_q;
		end
		if (cmd.div_en) begin
			avg_r_q <= avg_div(sum_r_q, cnt_q);
			avg_g_q <= avg_div(sum_g_q, cnt_q);
			avg_b_q <= avg_div(sum_b_q, cnt_q);
		end
		if (cmd.blend_en) begin
			out_q.out_column <= COORD_W'(ecol);
			out_q.out_row    <= COORD_W'(erow);
			out_q.red_out    <= blend(sat_s, orig_q[23:16], avg_r_q);
			out_q.green_out  <= blend(sat_s, orig_q[15:8], avg_g_q);
			out_q.blue_out   <= blend(sat_s, orig_q[7:0], avg_b_q);
			out_q.run_last   <= cmd.last;
		end
	end

	assign out_data = out_q;

endmodule

>>> hdl/box_blur_blend_3x3.sv
// Top level of the 3x3 box blur blend block.
// Usage:
// - Input channel (in_valid/in_stall/in_data): one RGB pixel per beat, raster order.
// - Output channel (out_valid/out_stall/out_data): filtered pixels with their
//   column and row; run_last marks the last result caused by one input beat.
// - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 width,
//   1 height, 2 strength in Q1.8. cfg_ready is always high. Writing width or
//   height restarts the frame. Write only while the block is idle.
// Sequencing:
// - A pixel that causes no result goes from idle to planning and back to idle.
// - Each result passes through planning, nine window reads through the single
//   line-store read port, drain, divide, blend and output, plus any output
//   stall. A pixel causes at most four results (row end, last row), and the
//   next pixel is taken only after the last of them is output.
// Reset clears the frame counters and loads width 256, height 256,
// strength 0. Line stores are not cleared; only written entries are used.
// While out_stall is high the result holds and in_stall stays high.
module box_blur_blend_3x3
	import bbb_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pixel_t               in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output result_t              out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	bbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bbb_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
